>>> rtl/ska_pkg.sv
// ----------------------------------------------------------------------------
// ska_pkg
// shared types and constants of the sorted key power accumulator
// ----------------------------------------------------------------------------
package ska_pkg;

    localparam int KEY_IN_W  = 16;
    localparam int POWER_W   = 16;
    localparam int IN_USER_W = 3;
    localparam int OUT_USER_W = 2;
    localparam int DATA_W    = KEY_IN_W + POWER_W;

    localparam logic signed [POWER_W:0] POWER_MAX = 17'sd32767;
    localparam logic signed [POWER_W:0] POWER_MIN = -17'sd32767;

    // s_axis_tuser bits
    localparam int U_NEGATE    = 0;
    localparam int U_START_NEW = 1;
    localparam int U_EMIT      = 2;

    // m_axis_tuser bits
    localparam int U_IS_EMPTY   = 0;
    localparam int U_OVERFLOWED = 1;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_SRCH_RD  = 10'b00_0000_0010,
        ST_SRCH_CHK = 10'b00_0000_0100,
        ST_DEL_RD   = 10'b00_0000_1000,
        ST_DEL_WR   = 10'b00_0001_0000,
        ST_INS_START = 10'b00_0010_0000,
        ST_INS_RD   = 10'b00_0100_0000,
        ST_INS_WR   = 10'b00_1000_0000,
        ST_DONE     = 10'b01_0000_0000,
        ST_EMIT     = 10'b10_0000_0000
    } state_t;

endpackage

>>> rtl/ska_ram.sv
// ----------------------------------------------------------------------------
// ska_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ska_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/sorted_key_power_accumulator_core.sv
// ----------------------------------------------------------------------------
// sorted_key_power_accumulator_core
// sorted table of keys with saturating signed powers, kept in one ram
// entries are compared or moved one at a time through the single ram port, so
// the time an item takes grows with the entries it compares or moves
// emit: results stream out in ascending key order, held by output stalls, then a new request is taken
// reset: async active low clears count, overflow flag, fsm and output valid
// ----------------------------------------------------------------------------
module sorted_key_power_accumulator_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_WIDTH   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ska_pkg::DATA_W-1:0]       s_axis_tdata,  // key, power
    input  logic [ska_pkg::IN_USER_W-1:0]    s_axis_tuser,  // negate, start_new, emit
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ska_pkg::DATA_W-1:0]       m_axis_tdata,  // out_key, out_power
    output logic                             m_axis_tlast,
    output logic [ska_pkg::OUT_USER_W-1:0]   m_axis_tuser   // is_empty, overflowed
);

    import ska_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = KEY_WIDTH + POWER_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    state_t state_reg, state_next;
    logic [KEY_WIDTH-1:0]      key_reg, key_next;
    logic signed [POWER_W-1:0] pow_reg, pow_next;
    logic                      emit_reg, emit_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic [CW-1:0]             pos_reg, pos_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      ovf_reg, ovf_next;

    logic                      ov_reg, ov_next;
    logic [KEY_IN_W-1:0]       okey_reg, okey_next;
    logic [POWER_W-1:0]        opow_reg, opow_next;
    logic                      olast_reg, olast_next;
    logic                      oempty_reg, oempty_next;
    logic                      oovf_reg, oovf_next;

    logic          wr_en, rd_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [RW-1:0] wr_data, rd_data;

    logic                      in_fire, out_free;
    logic [31:0]               key_wide, rd_key_wide;
    logic [KEY_WIDTH-1:0]      key_in, rd_key;
    logic signed [POWER_W-1:0] rd_pow;
    logic signed [POWER_W:0]   term, sum;
    logic [CW-1:0]             idx_inc, idx_dec;

    ska_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ov_reg || m_axis_tready;

    assign key_wide = {16'b0, s_axis_tdata[KEY_IN_W-1:0]};
    assign key_in   = key_wide[KEY_WIDTH-1:0];
    assign rd_key   = rd_data[KEY_WIDTH-1:0];
    assign rd_pow   = rd_data[RW-1:KEY_WIDTH];
    assign rd_key_wide = 32'(rd_key);
    assign idx_inc  = idx_reg + ONE_C;
    assign idx_dec  = idx_reg - ONE_C;

    // signed term, negated when the negate user bit is set
    always_comb
    begin
        logic signed [POWER_W:0] pw;
        pw   = {s_axis_tdata[DATA_W-1], s_axis_tdata[DATA_W-1:KEY_IN_W]};
        term = s_axis_tuser[U_NEGATE] ? -pw : pw;
    end

    assign sum = {rd_pow[POWER_W-1], rd_pow} + {pow_reg[POWER_W-1], pow_reg};

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        pow_next   = pow_reg;
        emit_next  = emit_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;

        ov_next     = ov_reg && !m_axis_tready;
        okey_next   = okey_reg;
        opow_next   = opow_reg;
        olast_next  = olast_reg;
        oempty_next = oempty_reg;
        oovf_next   = oovf_reg;

        wr_en   = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_data = {pow_reg, key_reg};
        rd_en   = 1'b0;
        rd_addr = idx_reg[IW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    key_next  = key_in;
                    emit_next = s_axis_tuser[U_EMIT];
                    idx_next  = '0;
                    if (s_axis_tuser[U_START_NEW])
                    begin
                        cnt_next = '0;
                        ovf_next = 1'b0;
                    end
                    if (term == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SRCH_RD;
                        if (term > POWER_MAX)
                        begin
                            pow_next = POWER_MAX[POWER_W-1:0];
                            ovf_next = 1'b1;
                        end
                        else if (term < POWER_MIN)
                        begin
                            pow_next = POWER_MIN[POWER_W-1:0];
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            pow_next = term[POWER_W-1:0];
                        end
                    end
                end
            end
            ST_SRCH_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    pos_next   = cnt_reg;
                    state_next = ST_INS_START;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_SRCH_CHK;
                end
            end
            ST_SRCH_CHK:
            begin
                if (rd_key == key_reg)
                begin
                    if (sum == '0)
                    begin
                        state_next = ST_DEL_RD;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        state_next = ST_DONE;
                        if (sum > POWER_MAX)
                        begin
                            wr_data  = {POWER_MAX[POWER_W-1:0], key_reg};
                            ovf_next = 1'b1;
                        end
                        else if (sum < POWER_MIN)
                        begin
                            wr_data  = {POWER_MIN[POWER_W-1:0], key_reg};
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            wr_data = {sum[POWER_W-1:0], key_reg};
                        end
                    end
                end
                else if (rd_key > key_reg)
                begin
                    pos_next   = idx_reg;
                    state_next = ST_INS_START;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_DEL_RD:
            begin
                if (idx_inc == cnt_reg)
                begin
                    cnt_next   = cnt_reg - ONE_C;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[IW-1:0];
                    state_next = ST_DEL_WR;
                end
            end
            ST_DEL_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                idx_next   = idx_inc;
                state_next = ST_DEL_RD;
            end
            ST_INS_START:
            begin
                state_next = ST_INS_RD;
                if (cnt_reg >= DEPTH_C)
                begin
                    ovf_next = 1'b1;
                    idx_next = DEPTH_C - ONE_C;
                    if (pos_reg >= DEPTH_C)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    idx_next = cnt_reg;
                    cnt_next = cnt_reg + ONE_C;
                end
            end
            ST_INS_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_dec[IW-1:0];
                    state_next = ST_INS_WR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                idx_next   = idx_dec;
                state_next = ST_INS_RD;
            end
            ST_DONE:
            begin
                idx_next   = '0;
                rd_addr    = '0;
                state_next = emit_reg ? ST_EMIT : ST_IDLE;
                if (emit_reg && cnt_reg != '0)
                begin
                    rd_en = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    oovf_next = ovf_reg;
                    if (cnt_reg == '0)
                    begin
                        okey_next   = '0;
                        opow_next   = '0;
                        olast_next  = 1'b1;
                        oempty_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        okey_next   = rd_key_wide[KEY_IN_W-1:0];
                        opow_next   = rd_pow;
                        olast_next  = (idx_inc == cnt_reg);
                        oempty_next = 1'b0;
                        idx_next    = idx_inc;
                        if (idx_inc == cnt_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = idx_inc[IW-1:0];
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            emit_reg  <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        pow_reg    <= pow_next;
        okey_reg   <= okey_next;
        opow_reg   <= opow_next;
        olast_reg  <= olast_next;
        oempty_reg <= oempty_next;
        oovf_reg   <= oovf_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {opow_reg, okey_reg};
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = {oovf_reg, oempty_reg};

endmodule
